@@ sv/dks_pkg.sv @@
// Shared types, permutation tables and helper functions for the DES key schedule.
// No dependencies; the step and top-level files refer to this package by scoped names.

package dks_pkg;

   localparam int unsigned HALF_BITS = 28;
   localparam int unsigned CD_BITS   = 56;
   localparam int unsigned KEY_BITS  = 64;
   localparam int unsigned RK_BITS   = 48;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_ENCRYPT = 2'd1,
      ACT_DECRYPT = 2'd2
   } action_type;

   typedef logic [HALF_BITS-1:0] half_type;

   typedef struct packed {
      action_type          action;
      logic [KEY_BITS-1:0] key_value;
      logic [3:0]          round_index;
   } item_type;

   typedef struct packed {
      logic [RK_BITS-1:0] round_key;
      half_type           c_half;
      half_type           d_half;
   } result_type;

   // Bit 1 is the most significant bit of the source word.
   localparam int PC1_TABLE [56] = '{
      57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
      10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
      63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
      14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
   };

   localparam int PC2_TABLE [48] = '{
      14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
      23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
      41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
      44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
   };

   function automatic logic [CD_BITS-1:0] perm_choice1(input logic [KEY_BITS-1:0] key);
      logic [CD_BITS-1:0] cd;
      cd = '0;
      for (int i = 0; i < 56; i++) begin
         cd[6'(55 - i)] = key[6'(64 - PC1_TABLE[i])];
      end
      return cd;
   endfunction

   function automatic logic [RK_BITS-1:0] perm_choice2(input logic [CD_BITS-1:0] cd);
      logic [RK_BITS-1:0] rk;
      rk = '0;
      for (int i = 0; i < 48; i++) begin
         rk[6'(47 - i)] = cd[6'(56 - PC2_TABLE[i])];
      end
      return rk;
   endfunction

   // Rounds 0, 1, 8 and 15 shift by one; all others by two.
   function automatic logic shift_by_two(input logic [3:0] round_index);
      logic one;
      one = (round_index == 4'd0) || (round_index == 4'd1) ||
            (round_index == 4'd8) || (round_index == 4'd15);
      return !one;
   endfunction

endpackage

@@ sv/dks_step.sv @@
// One key schedule step: load, encrypt rotate-then-PC2, or decrypt PC2-then-rotate.
// Purely combinational; uses dks_pkg types, tables and functions.

module dks_step (
   input  dks_pkg::item_type   item,
   input  dks_pkg::half_type   c_cur,
   input  dks_pkg::half_type   d_cur,
   output dks_pkg::result_type result
);

   logic                         two;
   dks_pkg::half_type            c_left;
   dks_pkg::half_type            d_left;
   dks_pkg::half_type            c_right;
   dks_pkg::half_type            d_right;
   logic [dks_pkg::CD_BITS-1:0]  cd_load;

   assign two     = dks_pkg::shift_by_two(item.round_index);
   assign c_left  = two ? {c_cur[25:0], c_cur[27:26]} : {c_cur[26:0], c_cur[27]};
   assign d_left  = two ? {d_cur[25:0], d_cur[27:26]} : {d_cur[26:0], d_cur[27]};
   assign c_right = two ? {c_cur[1:0], c_cur[27:2]} : {c_cur[0], c_cur[27:1]};
   assign d_right = two ? {d_cur[1:0], d_cur[27:2]} : {d_cur[0], d_cur[27:1]};
   assign cd_load = dks_pkg::perm_choice1(item.key_value);

   always_comb begin
      case (item.action)
         dks_pkg::ACT_LOAD: begin
            result.round_key = '0;
            result.c_half    = cd_load[55:28];
            result.d_half    = cd_load[27:0];
         end
         dks_pkg::ACT_ENCRYPT: begin
            result.round_key = dks_pkg::perm_choice2({c_left, d_left});
            result.c_half    = c_left;
            result.d_half    = d_left;
         end
         dks_pkg::ACT_DECRYPT: begin
            result.round_key = dks_pkg::perm_choice2({c_cur, d_cur});
            result.c_half    = c_right;
            result.d_half    = d_right;
         end
         default: begin
            // unused code: keep the halves, give a zero key
            result.round_key = '0;
            result.c_half    = c_cur;
            result.d_half    = d_cur;
         end
      endcase
   end

endmodule

@@ sv/des_key_schedule.sv @@
// DES key schedule: input register, one step of logic, result register.
// An accepted request beat passes the input register, then the result register, to its response beat.
// Throughput: one beat per cycle while the response side accepts; the C/D half registers
// close their loop through the single step path (the rotate and load mux, not PC-2).
// Reset (synchronous, active high) clears both halves to zero and empties both stages.

module des_key_schedule (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // key_value[63:0], round_index[67:64], zero pad
   input  logic [1:0]   req_tuser,   // action[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata    // round_key[47:0], c_half[75:48], d_half[103:76]
);

   logic                in_valid_ff, in_valid_in;
   dks_pkg::item_type   item_ff, item_in;
   logic                out_valid_ff, out_valid_in;
   dks_pkg::result_type result_ff, result_in;
   dks_pkg::half_type   c_ff, c_in;
   dks_pkg::half_type   d_ff, d_in;
   logic                fire;

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      item_in.action      = dks_pkg::action_type'(req_tuser);
      item_in.key_value   = req_tdata[63:0];
      item_in.round_index = req_tdata[67:64];
   end

   dks_step u_step (
      .item   (item_ff),
      .c_cur  (c_ff),
      .d_cur  (d_ff),
      .result (result_in)
   );

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      out_valid_in = fire ? 1'b1 : (out_valid_ff && !rsp_tready);
      c_in         = fire ? result_in.c_half : c_ff;
      d_in         = fire ? result_in.d_half : d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         c_ff         <= '0;
         d_ff         <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         c_ff         <= c_in;
         d_ff         <= d_in;
      end
   end

   // payload: load on acceptance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {result_ff.d_half, result_ff.c_half, result_ff.round_key};

endmodule

@@ sv/dks_checker.sv @@
// Port-level checks for des_key_schedule, attached by the bind at the end of this file.
// Depends on the top level's port list only.

module dks_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response beat changed");

   // an output with room never blocks the input side
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request blocked while response side has room");

   // every accepted request has a response beat pending after the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("accepted request produced no response beat");

   // reset empties the response stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind des_key_schedule dks_checker u_dks_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
